/* design/bgce_pkg.sv */
package bgce_pkg;

  // bit positions never pass offset + count, at most 2047 + 4095, which fits in 13 bits
  localparam int PosW = 13;

  typedef enum logic [1:0] {
    REQ_WR_SRC = 2'd0,
    REQ_WR_DST = 2'd1,
    REQ_RD_DST = 2'd2,
    REQ_COPY   = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_FETCH,
    ST_WR_SRC,
    ST_WR_DST,
    ST_RD_DST,
    ST_RD_CAP,
    ST_CHECK,
    ST_LOAD0,
    ST_MERGE,
    ST_READ,
    ST_RESP
  } step_t;

  typedef enum logic [1:0] {
    SRD_NONE,
    SRD_CUR,
    SRD_NEXT
  } src_rd_t;

  typedef enum logic [1:0] {
    DRD_NONE,
    DRD_ADDR,
    DRD_COPY
  } dst_rd_t;

  typedef enum logic [2:0] {
    BR_GOTO,
    BR_CLEAR,
    BR_DISPATCH,
    BR_CHECK,
    BR_LOOP,
    BR_OUT
  } branch_t;

  typedef struct packed {
    logic    clr_wr;
    logic    accept;
    logic    src_wr;
    logic    dst_wr;
    src_rd_t src_rd;
    dst_rd_t dst_rd;
    logic    cap_rd;
    logic    ld_b0;
    logic    check;
    logic    merge;
    logic    out_ld;
  } ctrl_t;

  typedef struct packed {
    ctrl_t   ctl;
    branch_t br;
    step_t   target;
  } uword_t;

  typedef struct packed {
    logic clr_done;
    logic range_err;
    logic zero_cnt;
    logic last;
    logic out_free;
  } flags_t;

  function automatic uword_t ucode(input step_t step);
    uword_t w;
    w = '0;
    w.br = BR_GOTO;
    w.target = ST_FETCH;
    case (step)
      ST_CLEAR: begin
        w.ctl.clr_wr = 1'b1;
        w.br = BR_CLEAR;
        w.target = ST_FETCH;
      end
      ST_FETCH: begin
        w.ctl.accept = 1'b1;
        w.br = BR_DISPATCH;
        w.target = ST_FETCH;
      end
      ST_WR_SRC: begin
        w.ctl.src_wr = 1'b1;
        w.target = ST_RESP;
      end
      ST_WR_DST: begin
        w.ctl.dst_wr = 1'b1;
        w.target = ST_RESP;
      end
      ST_RD_DST: begin
        w.ctl.dst_rd = DRD_ADDR;
        w.target = ST_RD_CAP;
      end
      ST_RD_CAP: begin
        w.ctl.cap_rd = 1'b1;
        w.target = ST_RESP;
      end
      ST_CHECK: begin
        w.ctl.check = 1'b1;
        w.ctl.src_rd = SRD_CUR;
        w.br = BR_CHECK;
        w.target = ST_LOAD0;
      end
      ST_LOAD0: begin
        w.ctl.ld_b0 = 1'b1;
        w.ctl.src_rd = SRD_NEXT;
        w.ctl.dst_rd = DRD_COPY;
        w.target = ST_MERGE;
      end
      ST_MERGE: begin
        w.ctl.merge = 1'b1;
        w.br = BR_LOOP;
        w.target = ST_READ;
      end
      ST_READ: begin
        w.ctl.src_rd = SRD_NEXT;
        w.ctl.dst_rd = DRD_COPY;
        w.target = ST_MERGE;
      end
      ST_RESP: begin
        w.ctl.out_ld = 1'b1;
        w.br = BR_OUT;
        w.target = ST_FETCH;
      end
      default: begin
        w.br = BR_GOTO;
        w.target = ST_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

/* design/bgce_sequencer.sv */
module bgce_sequencer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_req_type,
  input  bgce_pkg::flags_t flags,
  output bgce_pkg::ctrl_t  ctl
);

  bgce_pkg::step_t  step_r;
  bgce_pkg::step_t  step_nxt;
  bgce_pkg::uword_t uw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= bgce_pkg::ST_CLEAR;
    end else begin
      step_r <= step_nxt;
    end
  end

  // control word for the current step
  always_comb begin
    uw = bgce_pkg::ucode(step_r);
    ctl = uw.ctl;
  end

  always_comb begin
    step_nxt = step_r;
    case (uw.br)
      bgce_pkg::BR_GOTO: begin
        step_nxt = uw.target;
      end
      bgce_pkg::BR_CLEAR: begin
        if (flags.clr_done) step_nxt = uw.target;
      end
      bgce_pkg::BR_DISPATCH: begin
        if (in_valid) begin
          case (bgce_pkg::req_t'(in_req_type))
            bgce_pkg::REQ_WR_SRC: step_nxt = bgce_pkg::ST_WR_SRC;
            bgce_pkg::REQ_WR_DST: step_nxt = bgce_pkg::ST_WR_DST;
            bgce_pkg::REQ_RD_DST: step_nxt = bgce_pkg::ST_RD_DST;
            default:              step_nxt = bgce_pkg::ST_CHECK;
          endcase
        end
      end
      bgce_pkg::BR_CHECK: begin
        if (flags.range_err || flags.zero_cnt) step_nxt = bgce_pkg::ST_RESP;
        else step_nxt = uw.target;
      end
      bgce_pkg::BR_LOOP: begin
        if (flags.last) step_nxt = bgce_pkg::ST_RESP;
        else step_nxt = uw.target;
      end
      bgce_pkg::BR_OUT: begin
        if (flags.out_free) step_nxt = uw.target;
      end
      default: begin
        step_nxt = uw.target;
      end
    endcase
  end

`ifndef SYNTH
  a_merge_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == bgce_pkg::ST_MERGE |->
      $past(step_r) == bgce_pkg::ST_LOAD0 || $past(step_r) == bgce_pkg::ST_READ)
    else $error("merge step entered without a preceding store read");
  a_copy_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == bgce_pkg::ST_FETCH && in_valid && in_req_type == bgce_pkg::REQ_COPY
      |=> step_r == bgce_pkg::ST_CHECK)
    else $error("copy transfer not dispatched to range check");
  a_resp_release: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == bgce_pkg::ST_RESP && flags.out_free |=> step_r == bgce_pkg::ST_FETCH)
    else $error("response step did not return to fetch");
`endif

endmodule

/* design/bgce_datapath.sv */
module bgce_datapath #(
  parameter int STORE_BYTES = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bgce_pkg::ctrl_t  ctl,
  output bgce_pkg::flags_t flags,
  input  logic             in_valid,
  input  logic [7:0]       in_address,
  input  logic [7:0]       in_write_data,
  input  logic [10:0]      in_src_bit_offset,
  input  logic [10:0]      in_dest_bit_offset,
  input  logic [11:0]      in_bit_count,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_read_data,
  output logic             out_status
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int BitsW = $clog2(8 * STORE_BYTES + 1);
  localparam int CmpW = (BitsW > 13) ? BitsW : 13;
  localparam logic [CmpW-1:0] StoreBits = CmpW'(8 * STORE_BYTES);
  localparam int PW = bgce_pkg::PosW;

  logic [7:0]    src_mem_r [STORE_BYTES];
  logic [7:0]    dst_mem_r [STORE_BYTES];
  logic [7:0]    src_q_r;
  logic [7:0]    dst_q_r;

  logic [7:0]    addr_r;
  logic [7:0]    wdata_r;
  logic [PW-1:0] sp_r;
  logic [PW-1:0] dp_r;
  logic [11:0]   rem_r;
  logic [7:0]    b0_r;
  logic [7:0]    res_rd_r;
  logic          res_err_r;
  logic [AW-1:0] clr_r;
  logic          out_valid_r;
  logic [7:0]    out_rd_r;
  logic          out_st_r;

  logic            accept;
  logic            in_store;
  logic            out_free;
  logic [PW-4:0]   sbyte;
  logic [PW-4:0]   dbyte;
  logic [PW-3:0]   sbyte_p1;
  logic            nxt_past;
  logic [7:0]      b1;
  logic [3:0]      avail;
  logic            last;
  logic [3:0]      n;
  logic [3:0]      lo4;
  logic [3:0]      hi4;
  logic [7:0]      mask;
  logic [15:0]     win;
  logic [7:0]      s8;
  logic [7:0]      newd;
  logic [PW-1:0]   sp_nxt;
  logic [PW-1:0]   dp_nxt;
  logic [11:0]     rem_nxt;
  logic            adv;
  logic            range_err;

  logic            src_we;
  logic [AW-1:0]   src_wa;
  logic [7:0]      src_wd;
  logic [AW-1:0]   src_ra;
  logic            dst_we;
  logic [AW-1:0]   dst_wa;
  logic [7:0]      dst_wd;
  logic [AW-1:0]   dst_ra;

  assign accept   = in_valid && ctl.accept;
  assign in_store = 32'(addr_r) < 32'(STORE_BYTES);
  assign out_free = !out_valid_r || !out_stall;

  // copy walk: one destination byte per merge
  assign sbyte    = sp_r[PW-1:3];
  assign dbyte    = dp_r[PW-1:3];
  assign sbyte_p1 = {1'b0, sbyte} + (PW-2)'(1);
  assign nxt_past = 32'(sbyte_p1) >= 32'(STORE_BYTES);
  assign b1       = nxt_past ? 8'd0 : src_q_r;
  assign avail    = 4'd8 - {1'b0, dp_r[2:0]};
  assign last     = rem_r <= {8'd0, avail};
  assign n        = last ? rem_r[3:0] : avail;
  assign lo4      = {1'b0, dp_r[2:0]};
  assign hi4      = lo4 + n;
  assign mask     = (8'hff >> lo4) & ~(8'hff >> hi4);
  assign win      = {b0_r, b1} << sp_r[2:0];
  assign s8       = win[15:8] >> dp_r[2:0];
  assign newd     = (dst_q_r & ~mask) | (s8 & mask);
  assign sp_nxt   = sp_r + PW'(n);
  assign dp_nxt   = dp_r + PW'(n);
  assign rem_nxt  = rem_r - 12'(n);
  assign adv      = sp_nxt[PW-1:3] != sbyte;

  assign range_err = (CmpW'(sp_r) + CmpW'(rem_r) > StoreBits) ||
                     (CmpW'(dp_r) + CmpW'(rem_r) > StoreBits);

  assign flags.clr_done  = clr_r == AW'(STORE_BYTES - 1);
  assign flags.range_err = range_err;
  assign flags.zero_cnt  = rem_r == 12'd0;
  assign flags.last      = last;
  assign flags.out_free  = out_free;

  // store port muxing
  always_comb begin
    src_we = ctl.clr_wr || (ctl.src_wr && in_store);
    src_wa = ctl.clr_wr ? clr_r : AW'(addr_r);
    src_wd = ctl.clr_wr ? 8'd0 : wdata_r;
    src_ra = (ctl.src_rd == bgce_pkg::SRD_NEXT) ? AW'(sbyte_p1) : AW'(sbyte);
    dst_we = ctl.clr_wr || (ctl.dst_wr && in_store) || ctl.merge;
    if (ctl.clr_wr) begin
      dst_wa = clr_r;
      dst_wd = 8'd0;
    end else if (ctl.merge) begin
      dst_wa = AW'(dbyte);
      dst_wd = newd;
    end else begin
      dst_wa = AW'(addr_r);
      dst_wd = wdata_r;
    end
    dst_ra = (ctl.dst_rd == bgce_pkg::DRD_COPY) ? AW'(dbyte) : AW'(addr_r);
  end

  always_ff @(posedge clk) begin
    if (src_we) src_mem_r[src_wa] <= src_wd;
    src_q_r <= src_mem_r[src_ra];
  end

  always_ff @(posedge clk) begin
    if (dst_we) dst_mem_r[dst_wa] <= dst_wd;
    dst_q_r <= dst_mem_r[dst_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.clr_wr) clr_r <= clr_r + AW'(1);
      if (ctl.out_ld && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r    <= in_address;
      wdata_r   <= in_write_data;
      sp_r      <= PW'(in_src_bit_offset);
      dp_r      <= PW'(in_dest_bit_offset);
      rem_r     <= in_bit_count;
      res_rd_r  <= 8'd0;
      res_err_r <= 1'b0;
    end
    if (ctl.cap_rd) res_rd_r <= in_store ? dst_q_r : 8'd0;
    if (ctl.check) res_err_r <= range_err;
    if (ctl.ld_b0) b0_r <= src_q_r;
    if (ctl.merge) begin
      sp_r  <= sp_nxt;
      dp_r  <= dp_nxt;
      rem_r <= rem_nxt;
      if (adv) b0_r <= b1;
    end
    if (ctl.out_ld && out_free) begin
      out_rd_r <= res_rd_r;
      out_st_r <= res_err_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_rd_r;
  assign out_status    = out_st_r;

`ifndef SYNTH
  a_merge_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.merge |-> 32'(dbyte) < 32'(STORE_BYTES))
    else $error("merge write outside destination store");
  a_merge_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.merge |-> rem_r != 12'd0 && !range_err)
    else $error("merge with no bits left or range out of store");
  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_st_r |-> out_rd_r == 8'd0)
    else $error("range error result carries read data");
`endif

endmodule

/* design/bit_granular_copy_engine.sv */
// steps after fetch: a write stores and responds; a read reads, captures and responds;
//   a copy checks, responds on a range error or empty copy, else loads and merges bytes
// throughput: one transfer at a time; each destination byte takes a read step and a
//   merge-and-write step; a waiting result sits in the output register
// reset: synchronous active-low; afterwards a clearing pass zeroes both stores,
//   one byte of each per cycle, before the first transfer is accepted
module bit_granular_copy_engine #(
  parameter int STORE_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_address,
  input  logic [7:0]  in_write_data,
  input  logic [10:0] in_src_bit_offset,
  input  logic [10:0] in_dest_bit_offset,
  input  logic [11:0] in_bit_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_status
);

  bgce_pkg::ctrl_t  ctl;
  bgce_pkg::flags_t flags;

  assign in_stall = !ctl.accept;

  bgce_sequencer u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .flags       (flags),
    .ctl         (ctl)
  );

  bgce_datapath #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .flags              (flags),
    .in_valid           (in_valid),
    .in_address         (in_address),
    .in_write_data      (in_write_data),
    .in_src_bit_offset  (in_src_bit_offset),
    .in_dest_bit_offset (in_dest_bit_offset),
    .in_bit_count       (in_bit_count),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_read_data      (out_read_data),
    .out_status         (out_status)
  );

endmodule
